// File: rtl/assert_macros.svh
// Assertion macros for the RTL; only the back end includes them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked assertion, off while in reset
`define CIV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Implication form: when cond holds, concl must hold in the same cycle
`define CIV_ASSERT_IMPL(label, cond, concl, msg) \
    `CIV_ASSERT(label, (cond) |-> (concl), msg)

`endif

// File: rtl/civ_pkg.sv
// Types, constants and helpers for the four-point cubic interpolator
`timescale 1ns / 1ps
package civ_pkg;

    localparam int DATA_WIDTH    = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int WIDE_W        = 48;
    localparam int DIFF_W        = DATA_WIDTH + 1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_ZERO_SPAN = 2'd1;
    localparam logic [1:0] STATUS_SAT       = 2'd2;

    typedef struct packed {
        logic                         command;
        logic signed [DATA_WIDTH-1:0] query_x;
        logic signed [DATA_WIDTH-1:0] point0_x;
        logic signed [DATA_WIDTH-1:0] point1_x;
        logic signed [DATA_WIDTH-1:0] point2_x;
        logic signed [DATA_WIDTH-1:0] point3_x;
        logic signed [DATA_WIDTH-1:0] point0_y;
        logic signed [DATA_WIDTH-1:0] point1_y;
        logic signed [DATA_WIDTH-1:0] point2_y;
        logic signed [DATA_WIDTH-1:0] point3_y;
    } civ_in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] interp_value;
        logic [1:0]                   status;
    } civ_out_t;

    // Classified item as it sits in the queue
    typedef struct packed {
        logic                         command;
        logic                         err;
        logic signed [DIFF_W-1:0]     span;
        logic signed [DIFF_W-1:0]     nq;
        logic signed [DIFF_W-1:0]     n1;
        logic signed [DIFF_W-1:0]     d1;
        logic signed [DIFF_W-1:0]     n2;
        logic signed [DIFF_W-1:0]     d2;
        logic signed [DIFF_W-1:0]     dy;
        logic signed [DATA_WIDTH-1:0] y1;
        logic signed [DATA_WIDTH-1:0] y2;
    } civ_job_t;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } civ_op_t;

    typedef struct packed {
        logic                     start;
        civ_op_t                  op;
        logic signed [WIDE_W-1:0] a;
        logic signed [WIDE_W-1:0] b;
    } civ_alu_req_t;

    typedef struct packed {
        logic                     done;
        logic                     sat;
        logic signed [WIDE_W-1:0] res;
    } civ_alu_rsp_t;

    typedef enum logic [2:0] {
        ALU_IDLE,
        ALU_MUL,
        ALU_MFIN,
        ALU_DIV,
        ALU_DFIN,
        ALU_DONE
    } civ_alu_state_t;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_DIV_S1,
        SEQ_DIV_S2,
        SEQ_MUL_A,
        SEQ_MUL_B,
        SEQ_DIV_T,
        SEQ_MUL_U1,
        SEQ_MUL_T2,
        SEQ_MUL_AU,
        SEQ_MUL_BT,
        SEQ_MUL_TU,
        SEQ_MUL_BEND,
        SEQ_FINAL
    } civ_seq_state_t;

    typedef struct packed {
        logic                     sat;
        logic signed [WIDE_W-1:0] val;
    } civ_wres_t;

    // Saturating add into the 48-bit intermediate range
    function automatic civ_wres_t wadd(input logic signed [WIDE_W:0] a,
                                       input logic signed [WIDE_W:0] b);
        logic signed [WIDE_W+1:0] s;
        civ_wres_t                r;
        s = (WIDE_W+2)'(a) + (WIDE_W+2)'(b);
        r.sat = 1'b0;
        r.val = s[WIDE_W-1:0];
        if (!s[WIDE_W+1] && (s[WIDE_W] || s[WIDE_W-1])) begin
            r.sat = 1'b1;
            r.val = {1'b0, {(WIDE_W-1){1'b1}}};
        end else if (s[WIDE_W+1] && !(s[WIDE_W] && s[WIDE_W-1])) begin
            r.sat = 1'b1;
            r.val = {1'b1, {(WIDE_W-1){1'b0}}};
        end
        return r;
    endfunction

endpackage

// File: rtl/cubic_interp_four_point_top.sv
// Each divide runs DATA_WIDTH+1+FRAC_BITS one-bit steps in the shared unit,
// each multiply four 24x24 partial products; items run one at a time in the back end.
// A two-deep job queue and an output register let input and result sides stall apart.
// Synchronous active-low reset empties the queue, drops the result and zeroes both coefficients.
`timescale 1ns / 1ps
module cubic_interp_four_point_top #(
    parameter int FRAC_BITS = civ_pkg::FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  civ_pkg::civ_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output civ_pkg::civ_out_t m_data
);
    import civ_pkg::*;

    logic         q_valid;
    civ_job_t     q_job;
    logic         q_pop;
    civ_alu_req_t alu_req;
    civ_alu_rsp_t alu_rsp;

    civ_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_job   (q_job),
        .q_pop   (q_pop)
    );

    civ_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .rsp     (alu_rsp)
    );

    civ_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_job   (q_job),
        .q_pop   (q_pop),
        .alu_req (alu_req),
        .alu_rsp (alu_rsp),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: rtl/civ_front.sv
// Front end: accepts items, flags zero spans, forms differences, queues jobs
`timescale 1ns / 1ps
module civ_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  civ_pkg::civ_in_t  s_data,
    output logic              q_valid,
    output civ_pkg::civ_job_t q_job,
    input  logic              q_pop
);
    import civ_pkg::*;

    localparam int QDEPTH = 2;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    civ_job_t          mem_reg [QDEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    civ_job_t          job_new;
    logic              push;

    always_comb begin
        job_new.command = s_data.command;
        job_new.err     = (s_data.point2_x == s_data.point1_x) ||
                          (s_data.command &&
                           ((s_data.point2_x == s_data.point0_x) ||
                            (s_data.point3_x == s_data.point1_x)));
        job_new.span = DIFF_W'(s_data.point2_x) - DIFF_W'(s_data.point1_x);
        job_new.nq   = DIFF_W'(s_data.query_x)  - DIFF_W'(s_data.point1_x);
        job_new.n1   = DIFF_W'(s_data.point2_y) - DIFF_W'(s_data.point0_y);
        job_new.d1   = DIFF_W'(s_data.point2_x) - DIFF_W'(s_data.point0_x);
        job_new.n2   = DIFF_W'(s_data.point3_y) - DIFF_W'(s_data.point1_y);
        job_new.d2   = DIFF_W'(s_data.point3_x) - DIFF_W'(s_data.point1_x);
        job_new.dy   = DIFF_W'(s_data.point2_y) - DIFF_W'(s_data.point1_y);
        job_new.y1   = s_data.point1_y;
        job_new.y2   = s_data.point2_y;
    end

    assign s_ready = (cnt_reg != CNT_W'(QDEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_job   = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= job_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !q_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (!push && q_pop) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/civ_alu.sv
// Shared iterative unit: 48x48 multiply in 24-bit pieces, restoring divide
`timescale 1ns / 1ps
module civ_alu #(
    parameter int FRAC_BITS = civ_pkg::FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  civ_pkg::civ_alu_req_t req,
    output civ_pkg::civ_alu_rsp_t rsp
);
    import civ_pkg::*;

    localparam int HALF     = WIDE_W / 2;
    localparam int PROD_W   = 2 * WIDE_W;
    localparam int DIV_BITS = DIFF_W + FRAC_BITS;
    localparam int REM_W    = DIFF_W + 1;
    localparam int CNT_W    = $clog2(DIV_BITS + 1);
    localparam int QX_W     = DIV_BITS + WIDE_W;

    civ_alu_state_t           state_reg;
    civ_alu_state_t           state_next;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     neg_reg;
    logic [WIDE_W-1:0]        am_reg;
    logic [WIDE_W-1:0]        bm_reg;
    logic [PROD_W-1:0]        acc_reg;
    logic [DIV_BITS-1:0]      num_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [DIV_BITS-1:0]      quo_reg;
    logic signed [WIDE_W-1:0] res_reg;
    logic                     sat_reg;

    logic [WIDE_W-1:0]        a_mag;
    logic [WIDE_W-1:0]        b_mag;
    logic [HALF-1:0]          a_sel;
    logic [HALF-1:0]          b_sel;
    logic [WIDE_W-1:0]        pp;
    logic [PROD_W-1:0]        pp_sh;
    logic [REM_W-1:0]         rem_sh;
    logic                     rem_ge;
    logic [PROD_W-1:0]        prod_r;
    logic                     mul_sat;
    logic [QX_W-1:0]          quo_x;
    logic                     div_sat;

    assign a_mag = req.a[WIDE_W-1] ? WIDE_W'(-req.a) : req.a;
    assign b_mag = req.b[WIDE_W-1] ? WIDE_W'(-req.b) : req.b;

    // partial products: lo*lo, lo*hi, hi*lo, hi*hi
    assign a_sel = cnt_reg[1] ? am_reg[WIDE_W-1:HALF] : am_reg[HALF-1:0];
    assign b_sel = cnt_reg[0] ? bm_reg[WIDE_W-1:HALF] : bm_reg[HALF-1:0];
    assign pp    = a_sel * b_sel;
    always_comb begin
        if (cnt_reg[0] ^ cnt_reg[1]) begin
            pp_sh = PROD_W'(pp) << HALF;
        end else if (cnt_reg[1]) begin
            pp_sh = PROD_W'(pp) << (2 * HALF);
        end else begin
            pp_sh = PROD_W'(pp);
        end
    end

    assign rem_sh = {rem_reg[REM_W-2:0], num_reg[DIV_BITS-1]};
    assign rem_ge = (rem_sh >= REM_W'(bm_reg[DIFF_W-1:0]));

    assign prod_r  = acc_reg >> FRAC_BITS;
    assign mul_sat = neg_reg ?
        ((|prod_r[PROD_W-1:WIDE_W]) || (prod_r[WIDE_W-1] && (|prod_r[WIDE_W-2:0]))) :
        (|prod_r[PROD_W-1:WIDE_W-1]);
    assign quo_x   = QX_W'(quo_reg);
    assign div_sat = |quo_x[QX_W-1:WIDE_W-1];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ALU_IDLE: begin
                if (req.start) begin
                    state_next = (req.op == OP_DIV) ? ALU_DIV : ALU_MUL;
                end
            end
            ALU_MUL:  if (cnt_reg == CNT_W'(3)) state_next = ALU_MFIN;
            ALU_DIV:  if (cnt_reg == CNT_W'(DIV_BITS - 1)) state_next = ALU_DFIN;
            ALU_MFIN: state_next = ALU_DONE;
            ALU_DFIN: state_next = ALU_DONE;
            ALU_DONE: state_next = ALU_IDLE;
            default:  state_next = ALU_IDLE;
        endcase
    end

    always_comb begin
        rsp.done = (state_reg == ALU_DONE);
        rsp.sat  = sat_reg;
        rsp.res  = res_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ALU_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ALU_IDLE: begin
                cnt_reg <= '0;
                neg_reg <= req.a[WIDE_W-1] ^ req.b[WIDE_W-1];
                am_reg  <= a_mag;
                bm_reg  <= b_mag;
                acc_reg <= '0;
                num_reg <= {a_mag[DIFF_W-1:0], {FRAC_BITS{1'b0}}};
                rem_reg <= '0;
                quo_reg <= '0;
            end
            ALU_MUL: begin
                acc_reg <= acc_reg + pp_sh;
                cnt_reg <= cnt_reg + 1'b1;
            end
            ALU_DIV: begin
                rem_reg <= rem_ge ? (rem_sh - REM_W'(bm_reg[DIFF_W-1:0])) : rem_sh;
                quo_reg <= {quo_reg[DIV_BITS-2:0], rem_ge};
                num_reg <= num_reg << 1;
                cnt_reg <= cnt_reg + 1'b1;
            end
            ALU_MFIN: begin
                sat_reg <= mul_sat;
                if (mul_sat) begin
                    res_reg <= neg_reg ? {1'b1, {(WIDE_W-1){1'b0}}}
                                       : {1'b0, {(WIDE_W-1){1'b1}}};
                end else begin
                    res_reg <= neg_reg ? -prod_r[WIDE_W-1:0] : prod_r[WIDE_W-1:0];
                end
            end
            ALU_DFIN: begin
                sat_reg <= div_sat;
                if (div_sat) begin
                    res_reg <= neg_reg ? {1'b1, {(WIDE_W-1){1'b0}}}
                                       : {1'b0, {(WIDE_W-1){1'b1}}};
                end else begin
                    res_reg <= neg_reg ? -quo_x[WIDE_W-1:0] : quo_x[WIDE_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// File: rtl/civ_back.sv
// Back end: sequences the coefficient and evaluation steps, holds the result
`timescale 1ns / 1ps
`include "assert_macros.svh"
module civ_back #(
    parameter int FRAC_BITS = civ_pkg::FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  civ_pkg::civ_job_t     q_job,
    output logic                  q_pop,
    output civ_pkg::civ_alu_req_t alu_req,
    input  civ_pkg::civ_alu_rsp_t alu_rsp,
    output logic                  m_valid,
    input  logic                  m_ready,
    output civ_pkg::civ_out_t     m_data
);
    import civ_pkg::*;

    localparam int W1 = WIDE_W + 1;

    civ_seq_state_t           state_reg;
    civ_seq_state_t           state_next;
    logic                     issued_reg;
    civ_job_t                 job_reg;
    logic                     sat_reg;
    logic signed [WIDE_W-1:0] coeff_a_reg;
    logic signed [WIDE_W-1:0] coeff_b_reg;
    logic signed [WIDE_W-1:0] s1_reg;
    logic signed [WIDE_W-1:0] s2_reg;
    logic signed [WIDE_W-1:0] ca_tmp_reg;
    logic signed [WIDE_W-1:0] t_reg;
    logic signed [WIDE_W-1:0] u_reg;
    logic signed [WIDE_W-1:0] m1_reg;
    logic signed [WIDE_W-1:0] lin_reg;
    logic signed [WIDE_W-1:0] m3_reg;
    logic signed [WIDE_W-1:0] bend_reg;
    logic signed [WIDE_W-1:0] tu_reg;
    logic signed [DATA_WIDTH-1:0] fin_val_reg;
    logic [1:0]               fin_status_reg;
    logic                     m_valid_reg;
    civ_out_t                 m_data_reg;

    logic signed [WIDE_W-1:0] one_w;
    logic                     is_op;
    logic                     out_free;
    civ_wres_t                add_res;
    logic                     fits;
    logic signed [DATA_WIDTH-1:0] clamp_val;
    logic                     step_sat;

    assign one_w    = WIDE_W'(1) << FRAC_BITS;
    assign is_op    = (state_reg != SEQ_IDLE) && (state_reg != SEQ_FINAL);
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // adds that follow a finished unit operation
    always_comb begin
        case (state_reg)
            SEQ_MUL_A:    add_res = wadd(W1'(alu_rsp.res), -W1'(job_reg.dy));
            SEQ_MUL_B:    add_res = wadd(-W1'(alu_rsp.res), W1'(job_reg.dy));
            SEQ_DIV_T:    add_res = wadd(W1'(one_w), -W1'(alu_rsp.res));
            SEQ_MUL_T2:   add_res = wadd(W1'(m1_reg), W1'(alu_rsp.res));
            SEQ_MUL_BT:   add_res = wadd(W1'(m3_reg), W1'(alu_rsp.res));
            SEQ_MUL_BEND: add_res = wadd(W1'(lin_reg), W1'(alu_rsp.res));
            default:      add_res = wadd('0, '0);
        endcase
    end

    assign fits = (&add_res.val[WIDE_W-1:DATA_WIDTH-1]) ||
                  !(|add_res.val[WIDE_W-1:DATA_WIDTH-1]);
    assign clamp_val = fits ? add_res.val[DATA_WIDTH-1:0] :
                       (add_res.val[WIDE_W-1] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                                              : {1'b0, {(DATA_WIDTH-1){1'b1}}});
    assign step_sat = alu_rsp.sat || add_res.sat;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE: begin
                if (q_valid) begin
                    if (q_job.err) begin
                        state_next = SEQ_FINAL;
                    end else if (q_job.command) begin
                        state_next = SEQ_DIV_S1;
                    end else begin
                        state_next = SEQ_DIV_T;
                    end
                end
            end
            SEQ_DIV_S1:   if (alu_rsp.done) state_next = SEQ_DIV_S2;
            SEQ_DIV_S2:   if (alu_rsp.done) state_next = SEQ_MUL_A;
            SEQ_MUL_A:    if (alu_rsp.done) state_next = SEQ_MUL_B;
            SEQ_MUL_B:    if (alu_rsp.done) state_next = SEQ_DIV_T;
            SEQ_DIV_T:    if (alu_rsp.done) state_next = SEQ_MUL_U1;
            SEQ_MUL_U1:   if (alu_rsp.done) state_next = SEQ_MUL_T2;
            SEQ_MUL_T2:   if (alu_rsp.done) state_next = SEQ_MUL_AU;
            SEQ_MUL_AU:   if (alu_rsp.done) state_next = SEQ_MUL_BT;
            SEQ_MUL_BT:   if (alu_rsp.done) state_next = SEQ_MUL_TU;
            SEQ_MUL_TU:   if (alu_rsp.done) state_next = SEQ_MUL_BEND;
            SEQ_MUL_BEND: if (alu_rsp.done) state_next = SEQ_FINAL;
            SEQ_FINAL:    if (out_free) state_next = SEQ_IDLE;
            default:      state_next = SEQ_IDLE;
        endcase
    end

    always_comb begin
        q_pop         = (state_reg == SEQ_IDLE) && q_valid;
        alu_req.start = is_op && !issued_reg;
        alu_req.op    = OP_MUL;
        alu_req.a     = '0;
        alu_req.b     = '0;
        case (state_reg)
            SEQ_DIV_S1: begin
                alu_req.op = OP_DIV;
                alu_req.a  = WIDE_W'(job_reg.n1);
                alu_req.b  = WIDE_W'(job_reg.d1);
            end
            SEQ_DIV_S2: begin
                alu_req.op = OP_DIV;
                alu_req.a  = WIDE_W'(job_reg.n2);
                alu_req.b  = WIDE_W'(job_reg.d2);
            end
            SEQ_MUL_A: begin
                alu_req.a = s1_reg;
                alu_req.b = WIDE_W'(job_reg.span);
            end
            SEQ_MUL_B: begin
                alu_req.a = s2_reg;
                alu_req.b = WIDE_W'(job_reg.span);
            end
            SEQ_DIV_T: begin
                alu_req.op = OP_DIV;
                alu_req.a  = WIDE_W'(job_reg.nq);
                alu_req.b  = WIDE_W'(job_reg.span);
            end
            SEQ_MUL_U1: begin
                alu_req.a = u_reg;
                alu_req.b = WIDE_W'(job_reg.y1);
            end
            SEQ_MUL_T2: begin
                alu_req.a = t_reg;
                alu_req.b = WIDE_W'(job_reg.y2);
            end
            SEQ_MUL_AU: begin
                alu_req.a = coeff_a_reg;
                alu_req.b = u_reg;
            end
            SEQ_MUL_BT: begin
                alu_req.a = coeff_b_reg;
                alu_req.b = t_reg;
            end
            SEQ_MUL_TU: begin
                alu_req.a = t_reg;
                alu_req.b = u_reg;
            end
            SEQ_MUL_BEND: begin
                alu_req.a = tu_reg;
                alu_req.b = bend_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SEQ_IDLE;
            issued_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            coeff_a_reg <= '0;
            coeff_b_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (alu_req.start) begin
                issued_reg <= 1'b1;
            end else if (alu_rsp.done) begin
                issued_reg <= 1'b0;
            end
            if (state_reg == SEQ_MUL_B && alu_rsp.done) begin
                coeff_a_reg <= ca_tmp_reg;
                coeff_b_reg <= add_res.val;
            end
            if (state_reg == SEQ_FINAL && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= q_job;
            sat_reg <= 1'b0;
            if (q_job.err) begin
                fin_val_reg    <= '0;
                fin_status_reg <= STATUS_ZERO_SPAN;
            end
        end
        if (is_op && alu_rsp.done) begin
            sat_reg <= sat_reg || step_sat;
            case (state_reg)
                SEQ_DIV_S1: s1_reg     <= alu_rsp.res;
                SEQ_DIV_S2: s2_reg     <= alu_rsp.res;
                SEQ_MUL_A:  ca_tmp_reg <= add_res.val;
                SEQ_DIV_T: begin
                    t_reg <= alu_rsp.res;
                    u_reg <= add_res.val;
                end
                SEQ_MUL_U1: m1_reg   <= alu_rsp.res;
                SEQ_MUL_T2: lin_reg  <= add_res.val;
                SEQ_MUL_AU: m3_reg   <= alu_rsp.res;
                SEQ_MUL_BT: bend_reg <= add_res.val;
                SEQ_MUL_TU: tu_reg   <= alu_rsp.res;
                SEQ_MUL_BEND: begin
                    fin_val_reg    <= clamp_val;
                    fin_status_reg <= (sat_reg || step_sat || !fits) ? STATUS_SAT
                                                                      : STATUS_OK;
                end
                default: begin
                end
            endcase
        end
        if (state_reg == SEQ_FINAL && out_free) begin
            m_data_reg.interp_value <= fin_val_reg;
            m_data_reg.status       <= fin_status_reg;
        end
    end

    `CIV_ASSERT_IMPL(a_done_issued, alu_rsp.done, issued_reg, "unit finished an op never issued")
    `CIV_ASSERT_IMPL(a_zero_span_val, m_valid_reg && m_data_reg.status == STATUS_ZERO_SPAN, m_data_reg.interp_value == '0, "zero span result not zero")
    `CIV_ASSERT(a_load_from_final, $rose(m_valid_reg) |-> $past(state_reg == SEQ_FINAL), "result beat appeared outside final step")

endmodule
